### rtl/core/pva_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pva_pkg: shared types and constants of the priority voice allocator
// Voice count, chip register map, command kinds and the job word passed from
// the front end to the write sequencer.
// ----------------------------------------------------------------------------
package pva_pkg;

  localparam int VOICES = 6;
  localparam int VIDX_W = $clog2(VOICES);
  localparam int MASK_W = 6;

  // Job queue between front end and write sequencer
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Stream word widths
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 24;

  // Sound chip register map
  localparam logic [7:0] REG_KEY      = 8'h00;
  localparam logic [7:0] REG_MAXVOL   = 8'h01;
  localparam logic [7:0] REG_PANVOL   = 8'h08;
  localparam logic [7:0] REG_START_LO = 8'h10;
  localparam logic [7:0] REG_START_HI = 8'h18;
  localparam logic [7:0] REG_STOP_LO  = 8'h20;
  localparam logic [7:0] REG_STOP_HI  = 8'h28;
  localparam logic [7:0] REG_FLAG_ACK = 8'h1C;
  localparam logic [7:0] KEY_OFF_BIT  = 8'h80;
  localparam logic [7:0] MAXVOL_VAL   = 8'h3F;

  // Write sequence steps of a play job
  localparam logic [2:0] STEP_KEYOFF   = 3'd0;
  localparam logic [2:0] STEP_PANVOL   = 3'd1;
  localparam logic [2:0] STEP_START_LO = 3'd2;
  localparam logic [2:0] STEP_START_HI = 3'd3;
  localparam logic [2:0] STEP_STOP_LO  = 3'd4;
  localparam logic [2:0] STEP_STOP_HI  = 3'd5;
  localparam logic [2:0] STEP_KEYON    = 3'd6;

  typedef enum logic [1:0] {
    ACT_PLAY = 2'd0,
    ACT_END  = 2'd1,
    ACT_RES  = 2'd2,
    ACT_VOL  = 2'd3
  } act_e;

  typedef struct packed {
    act_e              kind;
    logic [VIDX_W-1:0] voice;
    logic              stop_first;
    logic [7:0]        panvol;
    logic [15:0]       start;
    logic [15:0]       stop;
    logic [7:0]        flags;
  } job_t;

  typedef struct packed {
    logic       last;
    logic [7:0] value;
    logic [7:0] addr;
    logic       port;
  } wr_t;

endpackage

### rtl/core/pva_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pva_front: command intake and voice selection
// Holds per-voice busy, reserved, code and priority state, picks a voice for
// play requests and pushes one job per command that produces writes.
// ----------------------------------------------------------------------------
module pva_front import pva_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  act_e        action_i,
  input  logic [7:0]  sound_code_i,
  input  logic [3:0]  priority_req_i,
  input  logic        retrigger_i,
  input  logic [7:0]  pan_volume_i,
  input  logic [15:0] sample_start_i,
  input  logic [15:0] sample_stop_i,
  input  logic [MASK_W-1:0] voice_mask_i,
  input  logic        q_full_i,
  output logic        push_o,
  output job_t        job_o
);

  logic [VOICES-1:0] busy_q, busy_d;
  logic [VOICES-1:0] res_q, res_d;
  logic [7:0]        code_q [VOICES];
  logic [3:0]        prio_q [VOICES];

  logic              accept;
  logic [7:0]        mask8;
  logic [VOICES-1:0] mask_v;
  logic              hit;
  logic              stop_first;
  logic [VIDX_W-1:0] sel;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign mask8      = 8'(voice_mask_i);
  assign mask_v     = mask8[VOICES-1:0];

  // Voice search: retrigger match, then first free, then the lowest-priority busy voice if below the request
  always_comb begin
    logic              m_found, f_found, l_found;
    logic [VIDX_W-1:0] m_idx, f_idx, l_idx;
    logic [3:0]        l_prio;
    m_found = 1'b0;
    f_found = 1'b0;
    l_found = 1'b0;
    m_idx   = '0;
    f_idx   = '0;
    l_idx   = '0;
    l_prio  = '0;
    for (int i = 0; i < VOICES; i++) begin
      if (retrigger_i && busy_q[i] && !res_q[i] && code_q[i] == sound_code_i &&
          !m_found) begin
        m_found = 1'b1;
        m_idx   = VIDX_W'(i);
      end
      if (!busy_q[i] && !res_q[i] && !f_found) begin
        f_found = 1'b1;
        f_idx   = VIDX_W'(i);
      end
      if (busy_q[i] && !res_q[i] && (!l_found || prio_q[i] < l_prio)) begin
        l_found = 1'b1;
        l_idx   = VIDX_W'(i);
        l_prio  = prio_q[i];
      end
    end
    priority if (m_found) begin
      hit        = 1'b1;
      stop_first = 1'b1;
      sel        = m_idx;
    end else if (f_found) begin
      hit        = 1'b1;
      stop_first = 1'b0;
      sel        = f_idx;
    end else if (l_found && l_prio < priority_req_i) begin
      hit        = 1'b1;
      stop_first = 1'b1;
      sel        = l_idx;
    end else begin
      hit        = 1'b0;
      stop_first = 1'b0;
      sel        = '0;
    end
  end

  always_comb begin
    busy_d = busy_q;
    res_d  = res_q;
    push_o = 1'b0;
    if (accept) begin
      unique case (action_i)
        ACT_PLAY: begin
          if (hit) begin
            busy_d[sel] = 1'b1;
            push_o      = 1'b1;
          end
        end
        ACT_END: begin
          busy_d = busy_q & ~mask_v;
          push_o = 1'b1;
        end
        ACT_RES: res_d  = mask_v;
        ACT_VOL: push_o = 1'b1;
        default: push_o = 1'b0;
      endcase
    end
  end

  assign job_o.kind       = action_i;
  assign job_o.voice      = sel;
  assign job_o.stop_first = stop_first;
  assign job_o.panvol     = pan_volume_i;
  assign job_o.start      = sample_start_i;
  assign job_o.stop       = sample_stop_i;
  assign job_o.flags      = 8'(mask_v);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
      res_q  <= '0;
      for (int i = 0; i < VOICES; i++) begin
        code_q[i] <= '0;
        prio_q[i] <= '0;
      end
    end else begin
      busy_q <= busy_d;
      res_q  <= res_d;
      for (int i = 0; i < VOICES; i++) begin
        if (accept && action_i == ACT_PLAY && hit && sel == VIDX_W'(i)) begin
          code_q[i] <= sound_code_i;
          prio_q[i] <= priority_req_i;
        end
      end
    end
  end

endmodule

### rtl/core/pva_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pva_queue: job queue
// Short first-in first-out buffer of jobs between intake and sequencer.
// ----------------------------------------------------------------------------
module pva_queue import pva_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  input  logic pop_i,
  output job_t head_o,
  output logic full_o,
  output logic empty_o
);

  job_t              entry_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

### rtl/core/pva_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pva_back: register write sequencer
// Takes one job at a time and steps through its chip writes, one word per
// cycle into an output register while the output is not stalled.
// ----------------------------------------------------------------------------
module pva_back import pva_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_empty_i,
  input  job_t q_head_i,
  output logic pop_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output wr_t  out_word_o
);

  logic       busy_q;
  job_t       job_q;
  logic [2:0] step_q;
  logic       ovalid_q;
  wr_t        oword_q;

  wr_t        word;
  logic       load;
  logic [7:0] vbit;
  logic [7:0] voff;

  assign vbit  = 8'(1) << job_q.voice;
  assign voff  = 8'(job_q.voice);
  assign pop_o = !busy_q && !q_empty_i;
  assign load  = busy_q && (!ovalid_q || out_ready_i);

  always_comb begin
    word = '0;
    unique case (job_q.kind)
      ACT_PLAY: begin
        word.port = 1'b1;
        unique case (step_q)
          STEP_KEYOFF: begin
            word.addr  = REG_KEY;
            word.value = KEY_OFF_BIT | vbit;
          end
          STEP_PANVOL: begin
            word.addr  = REG_PANVOL + voff;
            word.value = job_q.panvol;
          end
          STEP_START_LO: begin
            word.addr  = REG_START_LO + voff;
            word.value = job_q.start[7:0];
          end
          STEP_START_HI: begin
            word.addr  = REG_START_HI + voff;
            word.value = job_q.start[15:8];
          end
          STEP_STOP_LO: begin
            word.addr  = REG_STOP_LO + voff;
            word.value = job_q.stop[7:0];
          end
          STEP_STOP_HI: begin
            word.addr  = REG_STOP_HI + voff;
            word.value = job_q.stop[15:8];
          end
          default: begin
            word.addr  = REG_KEY;
            word.value = vbit;
            word.last  = 1'b1;
          end
        endcase
      end
      ACT_END: begin
        word.port = 1'b0;
        word.addr = REG_FLAG_ACK;
        // second write clears the acknowledge
        if (step_q == STEP_KEYOFF) begin
          word.value = job_q.flags;
        end else begin
          word.value = '0;
          word.last  = 1'b1;
        end
      end
      ACT_VOL: begin
        word.port  = 1'b1;
        word.addr  = REG_MAXVOL;
        word.value = MAXVOL_VAL;
        word.last  = 1'b1;
      end
      default: word.last = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= q_head_i;
    end
    if (load) begin
      oword_q <= word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      step_q   <= STEP_KEYOFF;
      ovalid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        busy_q <= 1'b1;
        // skip the key-off write when the voice was free
        step_q <= (q_head_i.kind == ACT_PLAY && !q_head_i.stop_first) ?
                  STEP_PANVOL : STEP_KEYOFF;
      end else if (load) begin
        if (word.last) begin
          busy_q <= 1'b0;
        end else begin
          step_q <= step_q + 1'b1;
        end
      end
      if (load) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_word_o  = oword_q;

endmodule

### rtl/core/priority_voice_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_voice_allocator_top: six-voice sample playback allocator
// Picks a voice for each sound request and streams the chip register writes.
// ----------------------------------------------------------------------------
// The front end takes a command word whenever the two-entry job queue has
// room, chooses a voice and updates the voice state at once; the write
// sequencer then emits one register write per cycle through its output
// register while the output is not stalled. A play request makes 6 writes
// on a free voice or 7 with key-off on a retriggered or stolen voice, after
// the job is fetched from the queue; end-flag acknowledge makes 2 writes,
// max volume 1, and a reserved-mask load or a dropped request writes
// nothing. The sustained rate is set by the sequencer's one-write-per-cycle
// output.
module priority_voice_allocator_top import pva_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // sound_code[7:0], priority_req[11:8], retrigger[12], pan_volume[20:13],
  // sample_start[36:21], sample_stop[52:37], voice_mask[58:53], zero fill
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // action[1:0]
  input  logic [1:0]            s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // port_select[0], reg_address[8:1], reg_value[16:9], zero fill
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic                  m_axis_tlast_o
);

  logic push, pop, q_full, q_empty;
  job_t push_job, head_job;
  wr_t  oword;

  pva_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid_i),
    .in_ready_o     (s_axis_tready_o),
    .action_i       (act_e'(s_axis_tuser_i)),
    .sound_code_i   (s_axis_tdata_i[7:0]),
    .priority_req_i (s_axis_tdata_i[11:8]),
    .retrigger_i    (s_axis_tdata_i[12]),
    .pan_volume_i   (s_axis_tdata_i[20:13]),
    .sample_start_i (s_axis_tdata_i[36:21]),
    .sample_stop_i  (s_axis_tdata_i[52:37]),
    .voice_mask_i   (s_axis_tdata_i[58:53]),
    .q_full_i       (q_full),
    .push_o         (push),
    .job_o          (push_job)
  );

  pva_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .head_o     (head_job),
    .full_o     (q_full),
    .empty_o    (q_empty)
  );

  pva_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (head_job),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_word_o  (oword)
  );

  assign m_axis_tdata_o = {7'd0, oword.value, oword.addr, oword.port};
  assign m_axis_tlast_o = oword.last;

endmodule

### rtl/core/pva_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pva_checker: port-level checks of the voice allocator
// Watches the output stream for register map rules of the write sequences.
// ----------------------------------------------------------------------------
module pva_checker import pva_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic                  m_axis_tlast_o
);

  // hold a stalled word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("stalled output word changed");

  // bank 0 carries only the flag acknowledge register
  a_bank0_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[0] |-> m_axis_tdata_o[8:1] == REG_FLAG_ACK)
    else $error("bank 0 write to unexpected register");

  // closing flag acknowledge writes zero
  a_ack_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o && !m_axis_tdata_o[0] |->
      m_axis_tdata_o[16:9] == 8'h00)
    else $error("final flag acknowledge not zero");

  // key-off is never the final write
  a_keyoff_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[0] && m_axis_tdata_o[8:1] == REG_KEY &&
    m_axis_tdata_o[16] |-> !m_axis_tlast_o)
    else $error("key-off write marked last");

  // outputs stay quiet while held in reset
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid_o)
    else $error("output valid during reset");

endmodule

bind priority_voice_allocator_top pva_checker u_pva_checker (.*);
